// ===== design/cdq_pkg.sv =====
`default_nettype none
package cdq_pkg;

  localparam int CAPACITY = 64;
  localparam int ID_BITS  = 8;
  localparam int ID_SPAN  = 2 ** ID_BITS;

  localparam int PTR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Port field widths.
  localparam int CMD_W   = 3;
  localparam int IDF_W   = 8;
  localparam int ST_W    = 2;
  localparam int OCC_W   = 7;
  localparam int IDCNT_W = 7;

  localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TAKE_TOP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TAKE_BOTTOM = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TAKE_FIRST  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TAKE_LAST   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PUT_TOP     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_PUT_BOTTOM  = 3'd6;
  localparam logic [CMD_W-1:0] CMD_QUERY       = 3'd7;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic load;
    logic decide;
    logic take_fin;
    logic search;
    logic shift;
    logic cnt_rd;
    logic cnt_wr;
    logic out_load;
  } dp_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             empty;
    logic             match_hit;
    logic             search_miss;
    logic             shift_done;
    logic             out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== design/cdq_ctrl.sv =====
`default_nettype none
module cdq_ctrl
  import cdq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_ctl_t       ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_TAKE   = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_CNT_RD = 3'd5;
  localparam logic [2:0] S_CNT_WR = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl          = '0;
    ctl.load     = in_valid && in_ready;
    ctl.decide   = (state == S_DECIDE);
    ctl.take_fin = (state == S_TAKE);
    ctl.search   = (state == S_SEARCH);
    ctl.shift    = (state == S_SHIFT);
    ctl.cnt_rd   = (state == S_CNT_RD);
    ctl.cnt_wr   = (state == S_CNT_WR);
    ctl.out_load = (state == S_DONE) && stat.out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        case (stat.cmd) inside
          CMD_TAKE_TOP, CMD_TAKE_BOTTOM:
            state_next = stat.empty ? S_CNT_RD : S_TAKE;
          CMD_TAKE_FIRST, CMD_TAKE_LAST:
            state_next = stat.empty ? S_CNT_RD : S_SEARCH;
          default:
            state_next = S_CNT_RD;
        endcase
      end
      S_TAKE: state_next = S_CNT_RD;
      S_SEARCH: begin
        if (stat.match_hit) state_next = S_SHIFT;
        else if (stat.search_miss) state_next = S_CNT_RD;
      end
      S_SHIFT: begin
        if (stat.shift_done) state_next = S_CNT_RD;
      end
      S_CNT_RD: state_next = S_CNT_WR;
      S_CNT_WR: state_next = S_DONE;
      S_DONE: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/cdq_datapath.sv =====
`default_nettype none
module cdq_datapath
  import cdq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dp_ctl_t            ctl,
  output dp_stat_t                stat,
  input  wire logic [CMD_W-1:0]   command,
  input  wire logic [IDF_W-1:0]   item_id,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [IDF_W-1:0]        taken_id,
  output logic [ST_W-1:0]         status,
  output logic [OCC_W-1:0]        occupancy,
  output logic [IDCNT_W-1:0]      id_count
);

  // Ring position of logical entry p counted from the top.
  function automatic logic [PTR_W-1:0] ring(input logic [PTR_W-1:0] base,
                                            input logic [CNT_W-1:0] p);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(base) + (CNT_W+1)'(p);
    if (s >= (CNT_W+1)'(CAPACITY)) s = s - (CNT_W+1)'(CAPACITY);
    return s[PTR_W-1:0];
  endfunction

  logic [ID_BITS-1:0] item_mem [CAPACITY];
  logic [ID_BITS-1:0] rdata;
  logic [CNT_W-1:0]   cnt_mem [ID_SPAN];
  logic [ID_SPAN-1:0] cnt_valid;
  logic [CNT_W-1:0]   cnt_rdata;
  logic               cnt_vld_rd;

  logic [PTR_W-1:0]   front;
  logic [CNT_W-1:0]   total;
  logic [CMD_W-1:0]   cmd_r;
  logic [ID_BITS-1:0] id_r;
  logic [ID_BITS-1:0] taken_r;
  logic [ST_W-1:0]    status_r;
  logic               took_r;
  logic               push_r;
  logic [CNT_W-1:0]   k;
  logic [CNT_W-1:0]   j;
  logic               pend;
  logic [CNT_W-1:0]   pend_pos;
  logic               pend_last;
  logic [CNT_W-1:0]   count_r;

  logic               empty;
  logic               full;
  logic [CNT_W-1:0]   total_m1;
  logic [PTR_W-1:0]   front_dec;
  logic [CNT_W-1:0]   scan_pos;
  logic               rd_en;
  logic [CNT_W-1:0]   rd_pos;
  logic               wr_en;
  logic [PTR_W-1:0]   wr_addr;
  logic [ID_BITS-1:0] wr_data;
  logic [ID_BITS-1:0] count_id;
  logic [CNT_W-1:0]   cnt_cur;
  logic [CNT_W-1:0]   cnt_new;
  logic               match_hit;

  assign empty     = (total == '0);
  assign full      = (total == CNT_W'(CAPACITY));
  assign total_m1  = total - CNT_W'(1);
  assign front_dec = (front == '0) ? PTR_W'(CAPACITY - 1) : front - PTR_W'(1);
  assign scan_pos  = (cmd_r == CMD_TAKE_FIRST) ? k : total_m1 - k;
  assign match_hit = pend && (rdata == id_r);
  assign count_id  = took_r ? taken_r : id_r;

  assign stat.cmd         = cmd_r;
  assign stat.empty       = empty;
  assign stat.match_hit   = match_hit;
  assign stat.search_miss = pend && !match_hit && pend_last;
  assign stat.shift_done  = !pend && (j >= total);
  assign stat.out_free    = !out_valid || out_ready;

  // Item memory read and write selection.
  always_comb begin
    rd_en   = 1'b0;
    rd_pos  = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = id_r;
    if (ctl.decide && !empty &&
        (cmd_r == CMD_TAKE_TOP || cmd_r == CMD_TAKE_BOTTOM)) begin
      rd_en  = 1'b1;
      rd_pos = (cmd_r == CMD_TAKE_TOP) ? '0 : total_m1;
    end
    if (ctl.decide && !full) begin
      if (cmd_r == CMD_PUT_TOP) begin
        wr_en   = 1'b1;
        wr_addr = front_dec;
      end else if (cmd_r == CMD_PUT_BOTTOM) begin
        wr_en   = 1'b1;
        wr_addr = ring(front, total);
      end
    end
    if (ctl.search && (k < total)) begin
      rd_en  = 1'b1;
      rd_pos = scan_pos;
    end
    if (ctl.shift) begin
      if (j < total) begin
        rd_en  = 1'b1;
        rd_pos = j;
      end
      if (pend) begin
        wr_en   = 1'b1;
        wr_addr = ring(front, pend_pos);
        wr_data = rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) item_mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= item_mem[ring(front, rd_pos)];
  end

  always_comb begin
    cnt_cur = cnt_vld_rd ? cnt_rdata : '0;
    cnt_new = cnt_cur;
    if (push_r) cnt_new = cnt_cur + CNT_W'(1);
    else if (took_r && cnt_cur != '0) cnt_new = cnt_cur - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (ctl.cnt_rd) begin
      cnt_rdata  <= cnt_mem[count_id];
      cnt_vld_rd <= cnt_valid[count_id];
    end
    if (ctl.cnt_wr) begin
      count_r <= cnt_new;
      if (push_r || took_r) cnt_mem[count_id] <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid <= '0;
    end else if (ctl.decide && cmd_r == CMD_CLEAR) begin
      cnt_valid <= '0;
    end else if (ctl.cnt_wr && (push_r || took_r)) begin
      cnt_valid[count_id] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      total <= '0;
      pend  <= 1'b0;
    end else begin
      if (ctl.decide) begin
        pend <= 1'b0;
        k    <= '0;
        case (cmd_r) inside
          CMD_CLEAR: begin
            front <= '0;
            total <= '0;
          end
          CMD_PUT_TOP, CMD_PUT_BOTTOM: begin
            if (!full) begin
              total <= total + CNT_W'(1);
              if (cmd_r == CMD_PUT_TOP) front <= front_dec;
            end
          end
          default: ;
        endcase
      end
      if (ctl.take_fin) begin
        total <= total_m1;
        if (cmd_r == CMD_TAKE_TOP) front <= ring(front, CNT_W'(1));
      end
      if (ctl.search) begin
        if (match_hit) begin
          // Entries below the match move up one place, starting right after it.
          pend <= 1'b0;
          j    <= pend_pos + CNT_W'(1);
        end else if (k < total) begin
          pend      <= 1'b1;
          pend_pos  <= scan_pos;
          pend_last <= (k == total_m1);
          k         <= k + CNT_W'(1);
        end else begin
          pend <= 1'b0;
        end
      end
      if (ctl.shift) begin
        if (j < total) begin
          pend     <= 1'b1;
          pend_pos <= j - CNT_W'(1);
          j        <= j + CNT_W'(1);
        end else begin
          pend <= 1'b0;
          if (!pend) total <= total_m1;
        end
      end
    end
  end

  // Per-request result bookkeeping.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= command;
      id_r  <= ID_BITS'(item_id);
    end
    if (ctl.decide) begin
      taken_r  <= '0;
      took_r   <= 1'b0;
      push_r   <= 1'b0;
      status_r <= ST_OK;
      case (cmd_r) inside
        CMD_TAKE_TOP, CMD_TAKE_BOTTOM, CMD_TAKE_FIRST, CMD_TAKE_LAST: begin
          if (empty) status_r <= ST_EMPTY;
        end
        CMD_PUT_TOP, CMD_PUT_BOTTOM: begin
          if (full) status_r <= ST_FULL;
          else push_r <= 1'b1;
        end
        default: ;
      endcase
    end
    if (ctl.take_fin) begin
      taken_r <= rdata;
      took_r  <= 1'b1;
    end
    if (ctl.search && stat.search_miss) status_r <= ST_NOT_FOUND;
    if (ctl.shift && stat.shift_done) begin
      taken_r <= id_r;
      took_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      taken_id  <= IDF_W'(taken_r);
      status    <= status_r;
      occupancy <= OCC_W'(total);
      id_count  <= IDCNT_W'(count_r);
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CNT_W'(CAPACITY))
    else $error("item total exceeds capacity");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> occupancy == OCC_W'(CAPACITY))
    else $error("full status with store not full");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> occupancy == '0)
    else $error("empty status with items stored");

  a_fail_no_take: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> taken_id == '0)
    else $error("failed request reports a taken id");

endmodule
`default_nettype wire

// ===== design/counted_deque_with_match_removal.sv =====
`default_nettype none
// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_ready  command, item_id
// result    out        out_valid/out_ready  taken_id, status, occupancy, id_count
//
// One request at a time. Clear, query and pushes pass through decide, count read,
// count write and done, the count memory read being registered; take top and take
// bottom add a take state for the registered item memory read. Match removal walks
// the item memory one entry per cycle through its single read port, scanning for the
// match, then moving each entry below it up one place. A new request is taken while
// a result waits; a stalled result holds the next one in its final state. Reset
// clears the counts at once through per-id valid bits; no clearing pass is needed.
module counted_deque_with_match_removal
  import cdq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [CMD_W-1:0]   command,
  input  wire logic [IDF_W-1:0]   item_id,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [IDF_W-1:0]        taken_id,
  output logic [ST_W-1:0]         status,
  output logic [OCC_W-1:0]        occupancy,
  output logic [IDCNT_W-1:0]      id_count
);

  dp_ctl_t  ctl;
  dp_stat_t stat;

  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  cdq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .command   (command),
    .item_id   (item_id),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .taken_id  (taken_id),
    .status    (status),
    .occupancy (occupancy),
    .id_count  (id_count)
  );

endmodule
`default_nettype wire
